>>> sv/asd_pkg.sv
// Shared types and constants for the analog axis scaler with dead zone.
package asd_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int VALUE_BITS_DEF = 16;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IN_LOW    = 3'd0,
		REG_IN_HIGH   = 3'd1,
		REG_OUT_LOW   = 3'd2,
		REG_OUT_HIGH  = 3'd3,
		REG_DEAD_ZONE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic dir_neg;
		logic dir_zero;
	} asd_ctl_t;

endpackage

>>> sv/asd_front.sv
// Front stages: clamp the sample, take its offset and multiply by the output span.
module asd_front import asd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [SAMPLE_BITS-1:0]            raw_sample,
	input  logic                              reverse_switch,
	input  logic                              forward_switch,
	input  logic [SAMPLE_BITS-1:0]            in_low,
	input  logic [SAMPLE_BITS-1:0]            in_high,
	input  logic                              span_ok,
	input  logic [VALUE_BITS-1:0]             diff_mag,
	output asd_ctl_t                          ctl_out,
	output logic [SAMPLE_BITS+VALUE_BITS-1:0] prod_out
);

	localparam int N = SAMPLE_BITS + VALUE_BITS;

	logic [SAMPLE_BITS-1:0] clamped;
	logic [SAMPLE_BITS-1:0] offset;
	asd_ctl_t ctl_s1;
	asd_ctl_t ctl_s2;
	logic [SAMPLE_BITS-1:0] off_s1;
	logic [N-1:0] prod_s2;

	always_comb begin
		if (raw_sample < in_low) begin
			clamped = in_low;
		end else if (raw_sample > in_high) begin
			clamped = in_high;
		end else begin
			clamped = raw_sample;
		end
		offset = span_ok ? (clamped - in_low) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.valid <= in_valid;
			ctl_s1.dir_neg <= ~reverse_switch;
			ctl_s1.dir_zero <= reverse_switch & forward_switch;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		off_s1 <= offset;
		prod_s2 <= N'(off_s1) * N'(diff_mag);
	end

	assign ctl_out = ctl_s2;
	assign prod_out = prod_s2;

endmodule

>>> sv/asd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module asd_div import asd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  asd_ctl_t                          ctl_in,
	input  logic [SAMPLE_BITS+VALUE_BITS-1:0] num_in,
	input  logic [SAMPLE_BITS-1:0]            divisor,
	output asd_ctl_t                          ctl_out,
	output logic [VALUE_BITS:0]               quo_out
);

	localparam int N = SAMPLE_BITS + VALUE_BITS;
	localparam int Q = VALUE_BITS + 1;

	// The quotient never exceeds the output span, so the top bits of the
	// numerator start out below the divisor.
	asd_ctl_t ctl_s [Q];
	logic [SAMPLE_BITS-1:0] rem_s [Q];
	logic [Q-1:0] low_s [Q];
	logic [Q-1:0] quo_s [Q];

	for (genvar k = 0; k < Q; k++) begin : g_stage
		asd_ctl_t ctl_prev;
		logic [SAMPLE_BITS-1:0] rem_prev;
		logic [Q-1:0] low_prev;
		logic [Q-1:0] quo_prev;
		logic [SAMPLE_BITS:0] trial;
		logic [SAMPLE_BITS:0] diff;
		logic ge;

		if (k == 0) begin : g_first
			assign ctl_prev = ctl_in;
			assign rem_prev = {1'b0, num_in[N-1:Q]};
			assign low_prev = num_in[Q-1:0];
			assign quo_prev = '0;
		end else begin : g_next
			assign ctl_prev = ctl_s[k-1];
			assign rem_prev = rem_s[k-1];
			assign low_prev = low_s[k-1];
			assign quo_prev = quo_s[k-1];
		end

		assign trial = {rem_prev, low_prev[Q-1]};
		assign diff = trial - {1'b0, divisor};
		assign ge = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_prev;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
			low_s[k] <= {low_prev[Q-2:0], 1'b0};
			quo_s[k] <= {quo_prev[Q-2:0], ge};
		end
	end

	assign ctl_out = ctl_s[Q-1];
	assign quo_out = quo_s[Q-1];

endmodule

>>> sv/asd_back.sv
// Back stages: add the output floor, apply direction and the dead zone.
module asd_back import asd_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  asd_ctl_t                     ctl_in,
	input  logic [VALUE_BITS:0]          quo_in,
	input  logic                         diff_neg,
	input  logic signed [VALUE_BITS-1:0] out_low,
	input  logic [VALUE_BITS-2:0]        dead_zone,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] axis_value
);

	localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic signed [VALUE_BITS+1:0] quo_ext;
	logic signed [VALUE_BITS+1:0] sum;
	logic [VALUE_BITS-1:0] dir_val;
	logic [VALUE_BITS-1:0] mag;
	asd_ctl_t ctl_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic done_s2;
	logic [VALUE_BITS-1:0] axis_s2;

	always_comb begin
		quo_ext = signed'({1'b0, quo_in});
		sum = {{2{out_low[VALUE_BITS-1]}}, out_low} + (diff_neg ? -quo_ext : quo_ext);
	end

	always_comb begin
		if (ctl_s1.dir_neg) begin
			dir_val = (val_s1 == VMIN) ? VMAX : -val_s1;
		end else if (ctl_s1.dir_zero) begin
			dir_val = '0;
		end else begin
			dir_val = val_s1;
		end
		mag = dir_val[VALUE_BITS-1] ? -dir_val : dir_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done_s2 <= 1'b0;
		end else begin
			ctl_s1 <= ctl_in;
			done_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		val_s1 <= sum[VALUE_BITS-1:0];
		axis_s2 <= (mag < {1'b0, dead_zone}) ? '0 : dir_val;
	end

	assign done = done_s2;
	assign axis_value = signed'(axis_s2);

endmodule

>>> sv/analog_axis_scale_deadband_core.sv
// Top level of the analog axis scaler: configuration registers and pipeline.
//
// A sample beat is taken at each rising edge where start is high; busy is
// always low, so a new sample may be offered in every cycle. The sample is
// clamped to the input range, mapped linearly onto the output range with a
// quotient truncated toward zero, turned by the direction switches and
// zeroed when its magnitude lies below the dead zone.
// Each result appears on axis_value for one cycle with done high, once its
// sample has passed the front stages, the divider stages and the back stages.
// The divider takes one quotient bit per stage; throughput is one beat per
// cycle. Results leave in the order of their samples and the receiver takes
// each one in the cycle it is shown. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no sample is
// in flight, as the block itself does not enforce this. Reset clears the
// pipeline control flags and loads the register defaults: full input range
// mapped onto zero to the largest positive value, with no dead zone.
module analog_axis_scale_deadband_core import asd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [SAMPLE_BITS-1:0]       raw_sample,
	input  logic                         reverse_switch,
	input  logic                         forward_switch,
	input  logic                         cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [((SAMPLE_BITS > VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS)-1:0] cfg_data,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] axis_value
);

	localparam int N = SAMPLE_BITS + VALUE_BITS;

	logic [SAMPLE_BITS-1:0] in_low_q;
	logic [SAMPLE_BITS-1:0] in_high_q;
	logic [VALUE_BITS-1:0] out_low_q;
	logic [VALUE_BITS-1:0] out_high_q;
	logic [VALUE_BITS-2:0] dead_zone_q;

	logic span_ok;
	logic [SAMPLE_BITS-1:0] divisor;
	logic signed [VALUE_BITS:0] out_diff;
	logic diff_neg;
	logic [VALUE_BITS-1:0] diff_mag;

	asd_ctl_t front_ctl;
	logic [N-1:0] front_prod;
	asd_ctl_t div_ctl;
	logic [VALUE_BITS:0] div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_low_q <= '0;
			in_high_q <= '1;
			out_low_q <= '0;
			out_high_q <= {1'b0, {(VALUE_BITS-1){1'b1}}};
			dead_zone_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IN_LOW: begin
					in_low_q <= cfg_data[SAMPLE_BITS-1:0];
				end
				REG_IN_HIGH: begin
					in_high_q <= cfg_data[SAMPLE_BITS-1:0];
				end
				REG_OUT_LOW: begin
					out_low_q <= cfg_data[VALUE_BITS-1:0];
				end
				REG_OUT_HIGH: begin
					out_high_q <= cfg_data[VALUE_BITS-1:0];
				end
				REG_DEAD_ZONE: begin
					dead_zone_q <= cfg_data[VALUE_BITS-2:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		span_ok = in_high_q > in_low_q;
		divisor = span_ok ? (in_high_q - in_low_q) : SAMPLE_BITS'(1);
		out_diff = signed'({out_high_q[VALUE_BITS-1], out_high_q})
			- signed'({out_low_q[VALUE_BITS-1], out_low_q});
		diff_neg = out_diff[VALUE_BITS];
		diff_mag = diff_neg ? VALUE_BITS'(-out_diff) : out_diff[VALUE_BITS-1:0];
	end

	assign busy = 1'b0;

	asd_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start),
		.raw_sample(raw_sample),
		.reverse_switch(reverse_switch),
		.forward_switch(forward_switch),
		.in_low(in_low_q),
		.in_high(in_high_q),
		.span_ok(span_ok),
		.diff_mag(diff_mag),
		.ctl_out(front_ctl),
		.prod_out(front_prod)
	);

	asd_div #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(front_ctl),
		.num_in(front_prod),
		.divisor(divisor),
		.ctl_out(div_ctl),
		.quo_out(div_quo)
	);

	asd_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(div_ctl),
		.quo_in(div_quo),
		.diff_neg(diff_neg),
		.out_low(signed'(out_low_q)),
		.dead_zone(dead_zone_q),
		.done(done),
		.axis_value(axis_value)
	);

endmodule
